/* design/hpack_huffman_decoder_unit_assert.svh */
// Assertion macros shared by the decoder's checker.
// Uses clk_i and rst_ni of the module that expands them.
`ifndef HPACK_HUFFMAN_DECODER_UNIT_ASSERT_SVH
`define HPACK_HUFFMAN_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define HPD_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define HPD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* design/hpd_pkg.sv */
// Shared constants, code tables and result type of the HPACK Huffman decoder.
// No dependencies.
`timescale 1ns / 1ps
package hpd_pkg;

  localparam int BufW     = 38;
  localparam int MinLen   = 5;
  localparam int MaxLen   = 30;
  localparam int EosBits  = 30;
  localparam int MaxPad   = 7;
  localparam int MaxSyms  = 3;
  localparam int InDepthDef  = 2;
  localparam int OutDepthDef = 4;

  localparam logic [1:0] KIND_SYM = 2'd0;
  localparam logic [1:0] KIND_END = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  typedef struct packed {
    logic [7:0] symbol;
    logic [1:0] kind;
    logic       run_last;
  } result_t;

  typedef logic [29:0] code_tab_t [256];
  typedef logic [4:0]  len_tab_t  [256];
  typedef logic [29:0] first_arr_t [MinLen:MaxLen];
  typedef logic [8:0]  num_arr_t   [MinLen:MaxLen];
  typedef logic [7:0]  sym_tab_t   [256];

  localparam code_tab_t CodeTab = '{
    30'h1ff8,30'h7fffd8,30'hfffffe2,30'hfffffe3,30'hfffffe4,30'hfffffe5,30'hfffffe6,
    30'hfffffe7,30'hfffffe8,30'hffffea,30'h3ffffffc,30'hfffffe9,30'hfffffea,30'h3ffffffd,
    30'hfffffeb,30'hfffffec,30'hfffffed,30'hfffffee,30'hfffffef,30'hffffff0,30'hffffff1,
    30'hffffff2,30'h3ffffffe,30'hffffff3,30'hffffff4,30'hffffff5,30'hffffff6,30'hffffff7,
    30'hffffff8,30'hffffff9,30'hffffffa,30'hffffffb,30'h14,30'h3f8,30'h3f9,30'hffa,
    30'h1ff9,30'h15,30'hf8,30'h7fa,30'h3fa,30'h3fb,30'hf9,30'h7fb,30'hfa,30'h16,30'h17,
    30'h18,30'h0,30'h1,30'h2,30'h19,30'h1a,30'h1b,30'h1c,30'h1d,30'h1e,30'h1f,30'h5c,
    30'hfb,30'h7ffc,30'h20,30'hffb,30'h3fc,30'h1ffa,30'h21,30'h5d,30'h5e,30'h5f,30'h60,
    30'h61,30'h62,30'h63,30'h64,30'h65,30'h66,30'h67,30'h68,30'h69,30'h6a,30'h6b,30'h6c,
    30'h6d,30'h6e,30'h6f,30'h70,30'h71,30'h72,30'hfc,30'h73,30'hfd,30'h1ffb,30'h7fff0,
    30'h1ffc,30'h3ffc,30'h22,30'h7ffd,30'h3,30'h23,30'h4,30'h24,30'h5,30'h25,30'h26,
    30'h27,30'h6,30'h74,30'h75,30'h28,30'h29,30'h2a,30'h7,30'h2b,30'h76,30'h2c,30'h8,
    30'h9,30'h2d,30'h77,30'h78,30'h79,30'h7a,30'h7b,30'h7ffe,30'h7fc,30'h3ffd,30'h1ffd,
    30'hffffffc,30'hfffe6,30'h3fffd2,30'hfffe7,30'hfffe8,30'h3fffd3,30'h3fffd4,
    30'h3fffd5,30'h7fffd9,30'h3fffd6,30'h7fffda,30'h7fffdb,30'h7fffdc,30'h7fffdd,
    30'h7fffde,30'hffffeb,30'h7fffdf,30'hffffec,30'hffffed,30'h3fffd7,30'h7fffe0,
    30'hffffee,30'h7fffe1,30'h7fffe2,30'h7fffe3,30'h7fffe4,30'h1fffdc,30'h3fffd8,
    30'h7fffe5,30'h3fffd9,30'h7fffe6,30'h7fffe7,30'hffffef,30'h3fffda,30'h1fffdd,
    30'hfffe9,30'h3fffdb,30'h3fffdc,30'h7fffe8,30'h7fffe9,30'h1fffde,30'h7fffea,
    30'h3fffdd,30'h3fffde,30'hfffff0,30'h1fffdf,30'h3fffdf,30'h7fffeb,30'h7fffec,
    30'h1fffe0,30'h1fffe1,30'h3fffe0,30'h1fffe2,30'h7fffed,30'h3fffe1,30'h7fffee,
    30'h7fffef,30'hfffea,30'h3fffe2,30'h3fffe3,30'h3fffe4,30'h7ffff0,30'h3fffe5,
    30'h3fffe6,30'h7ffff1,30'h3ffffe0,30'h3ffffe1,30'hfffeb,30'h7fff1,30'h3fffe7,
    30'h7ffff2,30'h3fffe8,30'h1ffffec,30'h3ffffe2,30'h3ffffe3,30'h3ffffe4,30'h7ffffde,
    30'h7ffffdf,30'h3ffffe5,30'hfffff1,30'h1ffffed,30'h7fff2,30'h1fffe3,30'h3ffffe6,
    30'h7ffffe0,30'h7ffffe1,30'h3ffffe7,30'h7ffffe2,30'hfffff2,30'h1fffe4,30'h1fffe5,
    30'h3ffffe8,30'h3ffffe9,30'hffffffd,30'h7ffffe3,30'h7ffffe4,30'h7ffffe5,30'hfffec,
    30'hfffff3,30'hfffed,30'h1fffe6,30'h3fffe9,30'h1fffe7,30'h1fffe8,30'h7ffff3,
    30'h3fffea,30'h3fffeb,30'h1ffffee,30'h1ffffef,30'hfffff4,30'hfffff5,30'h3ffffea,
    30'h7ffff4,30'h3ffffeb,30'h7ffffe6,30'h3ffffec,30'h3ffffed,30'h7ffffe7,30'h7ffffe8,
    30'h7ffffe9,30'h7ffffea,30'h7ffffeb,30'hffffffe,30'h7ffffec,30'h7ffffed,30'h7ffffee,
    30'h7ffffef,30'h7fffff0,30'h3ffffee
  };

  localparam len_tab_t LenTab = '{
    5'd13,5'd23,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd24,5'd30,5'd28,5'd28,5'd30,
    5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd30,5'd28,5'd28,5'd28,5'd28,5'd28,
    5'd28,5'd28,5'd28,5'd28,5'd6,5'd10,5'd10,5'd12,5'd13,5'd6,5'd8,5'd11,5'd10,5'd10,
    5'd8,5'd11,5'd8,5'd6,5'd6,5'd6,5'd5,5'd5,5'd5,5'd6,5'd6,5'd6,5'd6,5'd6,5'd6,5'd6,
    5'd7,5'd8,5'd15,5'd6,5'd12,5'd10,5'd13,5'd6,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
    5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd8,
    5'd7,5'd8,5'd13,5'd19,5'd13,5'd14,5'd6,5'd15,5'd5,5'd6,5'd5,5'd6,5'd5,5'd6,5'd6,
    5'd6,5'd5,5'd7,5'd7,5'd6,5'd6,5'd6,5'd5,5'd6,5'd7,5'd6,5'd5,5'd5,5'd6,5'd7,5'd7,
    5'd7,5'd7,5'd7,5'd15,5'd11,5'd14,5'd13,5'd28,5'd20,5'd22,5'd20,5'd20,5'd22,5'd22,
    5'd22,5'd23,5'd22,5'd23,5'd23,5'd23,5'd23,5'd23,5'd24,5'd23,5'd24,5'd24,5'd22,
    5'd23,5'd24,5'd23,5'd23,5'd23,5'd23,5'd21,5'd22,5'd23,5'd22,5'd23,5'd23,5'd24,
    5'd22,5'd21,5'd20,5'd22,5'd22,5'd23,5'd23,5'd21,5'd23,5'd22,5'd22,5'd24,5'd21,
    5'd22,5'd23,5'd23,5'd21,5'd21,5'd22,5'd21,5'd23,5'd22,5'd23,5'd23,5'd20,5'd22,
    5'd22,5'd22,5'd23,5'd22,5'd22,5'd23,5'd26,5'd26,5'd20,5'd19,5'd22,5'd23,5'd22,
    5'd25,5'd26,5'd26,5'd26,5'd27,5'd27,5'd26,5'd24,5'd25,5'd19,5'd21,5'd26,5'd27,
    5'd27,5'd26,5'd27,5'd24,5'd21,5'd21,5'd26,5'd26,5'd28,5'd27,5'd27,5'd27,5'd20,
    5'd24,5'd20,5'd21,5'd22,5'd21,5'd21,5'd23,5'd22,5'd22,5'd25,5'd25,5'd24,5'd24,
    5'd26,5'd23,5'd26,5'd27,5'd26,5'd26,5'd27,5'd27,5'd27,5'd27,5'd27,5'd28,5'd27,
    5'd27,5'd27,5'd27,5'd27,5'd26
  };

  // The code is canonical: within one length, codes rise with the symbol value.
  function automatic first_arr_t calc_first();
    first_arr_t r;
    for (int l = MinLen; l <= MaxLen; l++) begin
      r[l] = '1;
      for (int s = 0; s < 256; s++) begin
        if (int'(LenTab[s]) == l && CodeTab[s] < r[l]) r[l] = CodeTab[s];
      end
    end
    return r;
  endfunction

  function automatic num_arr_t calc_count();
    num_arr_t r;
    for (int l = MinLen; l <= MaxLen; l++) begin
      r[l] = '0;
      for (int s = 0; s < 256; s++) begin
        if (int'(LenTab[s]) == l) r[l] = r[l] + 9'd1;
      end
    end
    return r;
  endfunction

  // rank of the first symbol of each length in (length, symbol) order
  function automatic num_arr_t calc_offset();
    num_arr_t r;
    logic [8:0] acc;
    acc = '0;
    for (int l = MinLen; l <= MaxLen; l++) begin
      r[l] = acc;
      for (int s = 0; s < 256; s++) begin
        if (int'(LenTab[s]) == l) acc = acc + 9'd1;
      end
    end
    return r;
  endfunction

  function automatic sym_tab_t calc_sorted();
    sym_tab_t r;
    int idx;
    idx = 0;
    for (int s = 0; s < 256; s++) r[s] = '0;
    for (int l = MinLen; l <= MaxLen; l++) begin
      for (int s = 0; s < 256; s++) begin
        if (int'(LenTab[s]) == l) begin
          r[idx] = 8'(s);
          idx++;
        end
      end
    end
    return r;
  endfunction

  localparam first_arr_t FirstCode = calc_first();
  localparam num_arr_t   SymCount  = calc_count();
  localparam num_arr_t   SymOffset = calc_offset();
  localparam sym_tab_t   SortedSym = calc_sorted();

endpackage

/* design/hpd_fifo.sv */
// Small register queue used on both sides of the decode engine.
// Depends on nothing.
`timescale 1ns / 1ps
module hpd_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end
endmodule

/* design/hpd_back.sv */
// Decode engine: bit window, canonical code match, padding check, result ordering.
// Depends on hpd_pkg.
`timescale 1ns / 1ps
module hpd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_empty_i,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  output logic             in_pop_o,
  input  logic             out_full_i,
  output logic             out_push_o,
  output hpd_pkg::result_t out_data_o
);
  import hpd_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StMatch = 2'd1;
  localparam logic [1:0] StFlush = 2'd2;

  logic [1:0]      st_q, st_d;
  logic [BufW-1:0] win_q, win_d;      // left-aligned unused bits
  logic [5:0]      cnt_q, cnt_d;
  logic            drop_q, drop_d;
  logic            last_q, last_d;
  logic [1:0]      nsym_q, nsym_d;
  logic            pend_v_q, pend_v_d;
  result_t         pend_q, pend_d;

  logic [MaxLen:MinLen] hit;
  logic [7:0]           rank [MinLen:MaxLen];
  logic                 any_hit;
  logic [4:0]           hit_len;
  logic [7:0]           hit_rank;
  logic                 pad_ok;

  for (genvar g = MinLen; g <= MaxLen; g++) begin : g_len
    logic [MaxLen-1:0] top, diff;
    assign top     = MaxLen'(win_q[BufW-1 -: g]);
    assign diff    = top - FirstCode[g];
    assign hit[g]  = (cnt_q >= 6'(g)) && (top >= FirstCode[g]) &&
                     (diff < MaxLen'(SymCount[g]));
    assign rank[g] = 8'(SymOffset[g] + diff[8:0]);
  end

  // shortest matching length wins; the code is prefix free anyway
  always_comb begin
    any_hit  = 1'b0;
    hit_len  = '0;
    hit_rank = '0;
    for (int l = MaxLen; l >= MinLen; l--) begin
      if (hit[l]) begin
        any_hit  = 1'b1;
        hit_len  = 5'(l);
        hit_rank = rank[l];
      end
    end
  end

  assign pad_ok = (cnt_q <= 6'(MaxPad)) &&
                  ((win_q[BufW-1 -: 8] | (8'hFF >> cnt_q[2:0])) == 8'hFF);

  always_comb begin
    st_d       = st_q;
    win_d      = win_q;
    cnt_d      = cnt_q;
    drop_d     = drop_q;
    last_d     = last_q;
    nsym_d     = nsym_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    in_pop_o   = 1'b0;
    out_push_o = 1'b0;
    out_data_o = pend_q;
    out_data_o.run_last = 1'b0;
    case (st_q)
      StIdle: begin
        if (!in_empty_i) begin
          in_pop_o = 1'b1;
          if (drop_q) begin
            if (in_last_i) drop_d = 1'b0;
          end else begin
            win_d  = win_q | ({in_byte_i, 30'd0} >> cnt_q);
            cnt_d  = cnt_q + 6'd8;
            last_d = in_last_i;
            nsym_d = '0;
            st_d   = StMatch;
          end
        end
      end
      StMatch: begin
        if (!out_full_i) begin
          if (nsym_q != 2'(MaxSyms) && any_hit) begin
            out_push_o = pend_v_q;
            pend_d     = '{symbol: SortedSym[hit_rank], kind: KIND_SYM, run_last: 1'b0};
            pend_v_d   = 1'b1;
            win_d      = win_q << hit_len;
            cnt_d      = cnt_q - 6'(hit_len);
            nsym_d     = nsym_q + 2'd1;
          end else if (nsym_q != 2'(MaxSyms) && cnt_q >= 6'(EosBits)) begin
            out_push_o = pend_v_q;
            pend_d     = '{symbol: 8'd0, kind: KIND_ERR, run_last: 1'b0};
            pend_v_d   = 1'b1;
            win_d      = '0;
            cnt_d      = '0;
            drop_d     = !last_q;
            st_d       = StFlush;
          end else if (last_q) begin
            out_push_o = pend_v_q;
            pend_d     = '{symbol: 8'd0, kind: pad_ok ? KIND_END : KIND_ERR, run_last: 1'b0};
            pend_v_d   = 1'b1;
            win_d      = '0;
            cnt_d      = '0;
            st_d       = StFlush;
          end else begin
            st_d = StFlush;
          end
        end
      end
      StFlush: begin
        if (pend_v_q) begin
          if (!out_full_i) begin
            out_push_o          = 1'b1;
            out_data_o.run_last = 1'b1;
            pend_v_d            = 1'b0;
            st_d                = StIdle;
          end
        end else begin
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      win_q    <= '0;
      cnt_q    <= '0;
      drop_q   <= 1'b0;
      last_q   <= 1'b0;
      nsym_q   <= '0;
      pend_v_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      win_q    <= win_d;
      cnt_q    <= cnt_d;
      drop_q   <= drop_d;
      last_q   <= last_d;
      nsym_q   <= nsym_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end
endmodule

/* design/hpack_huffman_decoder_unit.sv */
// Top level of the HPACK Huffman string decoder.
// Depends on hpd_pkg, hpd_fifo and hpd_back.
//
// Input side is a queue: drive code_byte_i/last_byte_i and raise push; a
// transfer happens when push is high and full is low. Bytes are msb first,
// last_byte_i marks the final byte of a string.
// Result side is a queue too: while empty is low the oldest result sits on
// symbol_o/kind_o/run_last_o; a transfer happens when pop is high and empty
// is low. kind_o is 0 for a symbol, 1 for a clean end, 2 for a bad string;
// run_last_o flags the last result caused by one byte.
// A byte goes through a small input queue into the decode engine, which
// loads the byte, decodes up to 3 symbols from it one at a time in its
// single match unit, runs a closing match step and then hands over the
// final result; it takes the next byte only once it is done with this one.
// A byte dropped after an error is only popped from the input queue.
// Reset empties both queues and clears the bit window and drop state.
// A stalled receiver fills the result queue, which stops the engine, which
// then fills the input queue and raises full.
`timescale 1ns / 1ps
module hpack_huffman_decoder_unit #(
  parameter int InDepth  = hpd_pkg::InDepthDef,
  parameter int OutDepth = hpd_pkg::OutDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] code_byte_i,
  input  logic       last_byte_i,
  input  logic       push,
  output logic       full,
  output logic [7:0] symbol_o,
  output logic [1:0] kind_o,
  output logic       run_last_o,
  output logic       empty,
  input  logic       pop
);
  import hpd_pkg::*;

  logic       in_empty, in_pop, out_full, out_push;
  logic [8:0] in_data;
  result_t    out_wdata, out_rdata;

  hpd_fifo #(.Width(9), .Depth(InDepth)) u_in_q (
    .clk_i, .rst_ni,
    .push_i (push),
    .wdata_i({code_byte_i, last_byte_i}),
    .full_o (full),
    .pop_i  (in_pop),
    .rdata_o(in_data),
    .empty_o(in_empty)
  );

  hpd_back u_back (
    .clk_i, .rst_ni,
    .in_empty_i(in_empty),
    .in_byte_i (in_data[8:1]),
    .in_last_i (in_data[0]),
    .in_pop_o  (in_pop),
    .out_full_i(out_full),
    .out_push_o(out_push),
    .out_data_o(out_wdata)
  );

  hpd_fifo #(.Width($bits(result_t)), .Depth(OutDepth)) u_out_q (
    .clk_i, .rst_ni,
    .push_i (out_push),
    .wdata_i(out_wdata),
    .full_o (out_full),
    .pop_i  (pop),
    .rdata_o(out_rdata),
    .empty_o(empty)
  );

  assign symbol_o   = out_rdata.symbol;
  assign kind_o     = out_rdata.kind;
  assign run_last_o = out_rdata.run_last;
endmodule

/* design/hpd_checker.sv */
// Port-level checks for the decoder, attached to the top level by bind.
// Depends on hpd_pkg and hpack_huffman_decoder_unit_assert.svh.
`timescale 1ns / 1ps
`include "hpack_huffman_decoder_unit_assert.svh"
module hpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic [7:0] symbol_o,
  input logic [1:0] kind_o,
  input logic       run_last_o,
  input logic       empty,
  input logic       pop
);
  import hpd_pkg::*;

  `HPD_ASSERT_NEXT(a_out_hold, !empty && !pop,
    !empty && $stable(symbol_o) && $stable(kind_o) && $stable(run_last_o),
    "result changed while stalled")
  `HPD_ASSERT_NOW(a_status_closes, !empty && kind_o != KIND_SYM, run_last_o,
    "end or error result not flagged as last of its byte")
  `HPD_ASSERT_NOW(a_status_no_sym, !empty && kind_o != KIND_SYM, symbol_o == 8'd0,
    "end or error result carries a symbol")
endmodule

bind hpack_huffman_decoder_unit hpd_checker u_hpd_checker (.*);
